FILE: sv/signed_binary_to_decimal_ascii_top_macros.svh
// Assertion macros shared by the signed binary to decimal ASCII block.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBDA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/sbda_pkg.sv
// Constants and types shared by the signed binary to decimal ASCII block.
package sbda_pkg;

   localparam int VALUE_WIDTH  = 64;
   localparam int CHAR_WIDTH   = 8;
   localparam int NUM_DIGITS   = 19;
   localparam int DIGIT_WIDTH  = 4;
   localparam int BIT_CNT_W    = 6;
   localparam int DIGIT_CNT_W  = 5;

   localparam logic [BIT_CNT_W-1:0]   LAST_BIT     = 6'd63;
   localparam logic [DIGIT_CNT_W-1:0] DIGITS_FULL  = 5'd19;
   localparam logic [DIGIT_CNT_W-1:0] DIGITS_ONE   = 5'd1;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_NINE   = 4'd9;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_ZERO   = 4'd0;
   localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO   = 8'd48;
   localparam logic [CHAR_WIDTH-1:0]  ASCII_MINUS  = 8'd45;

   typedef struct packed {
      logic load;
      logic convert;
      logic shift;
   } sbda_cell_ctrl_type;

endpackage

FILE: sv/signed_binary_to_decimal_ascii_top.sv
// Top level: signed 64-bit integer to decimal ASCII text, one character per beat.
//
// channel  direction  payload                         handshake
// req      in         tdata[63:0] value (signed)      req_tvalid / req_tready
// rsp      out        tdata[7:0] character, tlast     rsp_tvalid / rsp_tready
//
// One value at a time: accept, then shift in one magnitude bit per cycle
// into a row of 19 digit cells, then scan the row from the top
// (leading zeros dropped, a settle step on the top digit, digits emitted),
// plus a beat for a minus sign ahead of the digits.
// Reset is synchronous and clears control state; a stalled rsp beat holds the row.
`include "signed_binary_to_decimal_ascii_top_macros.svh"

module signed_binary_to_decimal_ascii_top
   import sbda_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [VALUE_WIDTH-1:0] req_tdata,  // [63:0] value
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [CHAR_WIDTH-1:0]  rsp_tdata,  // [7:0] character
   output logic                   rsp_tlast
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CONVERT = 4'b0010,
      ST_SKIP    = 4'b0100,
      ST_EMIT    = 4'b1000
   } sbda_state_type;

   sbda_state_type         state_ff, state_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIGIT_CNT_W-1:0] digits_left_ff, digits_left_in;
   logic                   sign_ff, sign_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]  rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   sbda_cell_ctrl_type     cell_ctrl;
   logic [NUM_DIGITS:0]    carry_w;
   logic [DIGIT_WIDTH-1:0] digit_w   [NUM_DIGITS];
   logic [DIGIT_WIDTH-1:0] digit_low [NUM_DIGITS];
   logic [DIGIT_WIDTH-1:0] top_digit;

   logic accept;
   logic out_free;
   logic skip_step;
   logic emit_digit;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign top_digit  = digit_w[NUM_DIGITS-1];
   assign skip_step  = (state_ff == ST_SKIP) && (top_digit == DIGIT_ZERO) &&
                       (digits_left_ff != DIGITS_ONE);
   assign emit_digit = (state_ff == ST_EMIT) && out_free && !sign_ff;

   assign cell_ctrl.load    = accept;
   assign cell_ctrl.convert = (state_ff == ST_CONVERT);
   assign cell_ctrl.shift   = skip_step || emit_digit;

   assign carry_w[0]   = mag_ff[VALUE_WIDTH-1];
   assign digit_low[0] = DIGIT_ZERO;

   genvar gi;
   generate
      for (gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
         if (gi > 0) begin : g_link
            assign digit_low[gi] = digit_w[gi-1];
         end
         sbda_digit_cell u_cell (
            .clock       (clock),
            .ctrl        (cell_ctrl),
            .lower_carry (carry_w[gi]),
            .lower_digit (digit_low[gi]),
            .carry_out   (carry_w[gi+1]),
            .digit       (digit_w[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in       = state_ff;
      bit_cnt_in     = bit_cnt_ff;
      digits_left_in = digits_left_ff;
      sign_in        = sign_ff;
      mag_in         = mag_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_char_in    = rsp_char_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sign_in    = req_tdata[VALUE_WIDTH-1];
               mag_in     = req_tdata[VALUE_WIDTH-1] ? (~req_tdata + 64'd1) : req_tdata;
               bit_cnt_in = '0;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 6'd1;
            if (bit_cnt_ff == LAST_BIT) begin
               digits_left_in = DIGITS_FULL;
               state_in       = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (skip_step) begin
               digits_left_in = digits_left_ff - 5'd1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_char_in = ASCII_MINUS;
                  rsp_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  rsp_char_in    = ASCII_ZERO + {4'd0, top_digit};
                  rsp_last_in    = (digits_left_ff == DIGITS_ONE);
                  digits_left_in = digits_left_ff - 5'd1;
                  if (digits_left_ff == DIGITS_ONE) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bit_cnt_ff     <= bit_cnt_in;
      digits_left_ff <= digits_left_in;
      sign_ff        <= sign_in;
      mag_ff         <= mag_in;
      rsp_char_ff    <= rsp_char_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

   `SBDA_ASSERT_NOW(a_no_row_overflow, clock, reset, state_ff == ST_CONVERT, !carry_w[NUM_DIGITS], "digit row overflowed during conversion")
   `SBDA_ASSERT_NEXT(a_accept_starts, clock, reset, accept, state_ff == ST_CONVERT && bit_cnt_ff == '0, "accept did not start conversion")
   `SBDA_ASSERT_NOW(a_emit_decimal, clock, reset, emit_digit, top_digit <= DIGIT_NINE, "emitted digit is not decimal")
   `SBDA_ASSERT_NOW(a_last_is_digit, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_char_ff != ASCII_MINUS, "last character is a minus sign")

endmodule

FILE: sv/sbda_digit_cell.sv
// One decimal digit cell of the shift-and-add-three conversion row.
module sbda_digit_cell
   import sbda_pkg::*;
(
   input  logic                   clock,
   input  sbda_cell_ctrl_type     ctrl,
   input  logic                   lower_carry,
   input  logic [DIGIT_WIDTH-1:0] lower_digit,
   output logic                   carry_out,
   output logic [DIGIT_WIDTH-1:0] digit
);

   logic [DIGIT_WIDTH-1:0] digit_ff;
   logic [DIGIT_WIDTH-1:0] digit_in;
   logic [DIGIT_WIDTH-1:0] adjusted;

   assign adjusted  = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign carry_out = adjusted[DIGIT_WIDTH-1];
   assign digit     = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.load) begin
         digit_in = DIGIT_ZERO;
      end else if (ctrl.convert) begin
         digit_in = {adjusted[DIGIT_WIDTH-2:0], lower_carry};
      end else if (ctrl.shift) begin
         digit_in = lower_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

FILE: tb/signed_binary_to_decimal_ascii_top_tb.sv
// Testbench for the signed 64-bit integer to decimal ASCII converter: directed table, then random.
module signed_binary_to_decimal_ascii_top_tb
   import sbda_pkg::*;
();

   localparam int DIRECTED_COUNT = 20;
   localparam int RANDOM_COUNT   = 410;
   localparam int TOTAL_COUNT    = DIRECTED_COUNT + RANDOM_COUNT;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } ascii_beat_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [VALUE_WIDTH-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [CHAR_WIDTH-1:0]  rsp_tdata;
   logic                   rsp_tlast;

   ascii_beat_type expected_chars [$];
   string          pending_text   = "";
   int             tx_idle_pct    = 33;
   int             rx_idle_pct    = 50;
   int unsigned    mismatches     = 0;

   logic [VALUE_WIDTH-1:0] directed_values [DIRECTED_COUNT] = '{
      64'd0,
      64'd1,
      -64'sd1,
      64'd9,
      64'd10,
      -64'sd10,
      64'd99,
      -64'sd100,
      64'h7FFF_FFFF_FFFF_FFFF,
      64'h8000_0000_0000_0000,
      64'h8000_0000_0000_0001,
      64'h7FFF_FFFF_FFFF_FFFE,
      64'd1000000000000000000,
      -64'sd1000000000000000000,
      64'd999999999999999999,
      64'd9000000000000000000,
      64'd123456789,
      -64'sd987654321,
      64'h5555_5555_5555_5555,
      64'hAAAA_AAAA_AAAA_AAAA
   };

   string directed_texts [DIRECTED_COUNT] = '{
      "0",
      "1",
      "-1",
      "9",
      "10",
      "", "", "",
      "9223372036854775807",
      "-9223372036854775808",
      "", "",
      "1000000000000000000",
      "-1000000000000000000",
      "", "", "", "", "", ""
   };

   signed_binary_to_decimal_ascii_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic logic [VALUE_WIDTH-1:0] power_of_ten(int n);
      logic [VALUE_WIDTH-1:0] p;
      p = 64'd1;
      for (int k = 0; k < n; k++) p = p * 64'd10;
      return p;
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] draw_value();
      int unsigned            pick;
      logic [VALUE_WIDTH-1:0] mag;
      pick = $urandom_range(0, 99);
      if (pick < 25) return {$urandom, $urandom};
      if (pick < 80) begin
         mag = {$urandom, $urandom} % power_of_ten($urandom_range(1, 18));
      end else if (pick < 95) begin
         mag = power_of_ten($urandom_range(0, 18)) - 64'($urandom_range(0, 1));
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               return 64'h8000_0000_0000_0000;
            end
            1: begin
               return 64'h7FFF_FFFF_FFFF_FFFF;
            end
            2: begin
               return 64'd0;
            end
            default: begin
               return '1;
            end
         endcase
      end
      return ($urandom_range(0, 1) != 0) ? -mag : mag;
   endfunction

   function automatic void predict_text(logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] mag;
      logic [3:0]             digits [NUM_DIGITS];
      int                     count;
      mag   = value[VALUE_WIDTH-1] ? ~value + 64'd1 : value;
      count = 0;
      do begin
         digits[count] = 4'(mag % 64'd10);
         count++;
         mag = mag / 64'd10;
      end while (mag != 0);
      if (value[VALUE_WIDTH-1]) expected_chars.push_back('{ASCII_MINUS, 1'b0});
      for (int k = count - 1; k >= 0; k--) begin
         expected_chars.push_back('{ASCII_ZERO + 8'(digits[k]), k == 0});
      end
   endfunction

   function automatic void push_typed_text(string text);
      for (int k = 0; k < text.len(); k++) begin
         expected_chars.push_back('{text[k], k == text.len() - 1});
      end
   endfunction

   always @(posedge clock) rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

   always @(posedge clock) begin
      ascii_beat_type want;
      if (!reset && req_tvalid && req_tready) begin
         if (pending_text.len() != 0) push_typed_text(pending_text);
         else predict_text(req_tdata);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected beat: char %0d last %0b", rsp_tdata, rsp_tlast);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tdata !== want.character || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("mismatch: char exp %0d got %0d, last exp %0b got %0b",
                           want.character, rsp_tdata, want.last, rsp_tlast);
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < TOTAL_COUNT; i++) begin
         if (i < TOTAL_COUNT / 3) begin
            tx_idle_pct = 33;
            rx_idle_pct = 50;
         end else if (i < 2 * TOTAL_COUNT / 3) begin
            tx_idle_pct = 50;
            rx_idle_pct = 33;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         if (i < DIRECTED_COUNT) begin
            req_tdata    <= directed_values[i];
            pending_text <= directed_texts[i];
         end else begin
            req_tdata    <= draw_value();
            pending_text <= "";
         end
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_chars.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
